>>> hw/rtl/smms_pkg.sv
`default_nettype none
package smms_pkg;

    localparam int SEG_W   = 10;
    localparam int LIGHT_W = 15;
    localparam int CHROMA_W = 8;
    localparam int CNT_W   = 23;
    localparam int MEAN_W  = 16;
    localparam int RATIO_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHTNESS_FLOOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_RATIO     = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic                command;
        logic [SEG_W-1:0]    segment;
        logic [LIGHT_W-1:0]  lightness;
        logic [CHROMA_W-1:0] chroma_a;
        logic [CHROMA_W-1:0] chroma_b;
    } req_t;

    typedef struct packed {
        logic              segment_valid;
        logic [CNT_W-1:0]  weight;
        logic [CNT_W-1:0]  total_count;
        logic [LIGHT_W-1:0] mean_lightness;
        logic [MEAN_W-1:0] mean_a;
        logic [MEAN_W-1:0] mean_b;
    } rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/smms_if.sv
`default_nettype none
interface smms_if #(
    parameter int W = 1
) (
    input wire logic clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/smms_div.sv
`default_nettype none
// Restoring divider for the three means, one quotient bit a cycle, the three
// numerators run in parallel over the same divisor.
module smms_div #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 23
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_W-1:0]    num_l,
    input  wire logic [NUM_W-1:0]    num_a,
    input  wire logic [NUM_W-1:0]    num_b,
    input  wire logic [DEN_W-1:0]    divisor,
    output logic                     done,
    output logic [NUM_W-1:0]         quo_l,
    output logic [NUM_W-1:0]         quo_a,
    output logic [NUM_W-1:0]         quo_b
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [NUM_W-1:0]  ql_reg, qa_reg, qb_reg;
    logic [DEN_W:0]    rl_reg, ra_reg, rb_reg;
    logic [NUM_W-1:0]  ql_next, qa_next, qb_next;
    logic [DEN_W:0]    rl_next, ra_next, rb_next;
    logic [DEN_W:0]    sl, sa, sb;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        ql_next = ql_reg;
        qa_next = qa_reg;
        qb_next = qb_reg;
        rl_next = rl_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        sl = {rl_reg[DEN_W-1:0], ql_reg[NUM_W-1]};
        sa = {ra_reg[DEN_W-1:0], qa_reg[NUM_W-1]};
        sb = {rb_reg[DEN_W-1:0], qb_reg[NUM_W-1]};
        done = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W);
            ql_next = num_l;
            qa_next = num_a;
            qb_next = num_b;
            rl_next = '0;
            ra_next = '0;
            rb_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
                if (sl >= {1'b0, divisor})
                begin
                    rl_next = sl - {1'b0, divisor};
                    ql_next = {ql_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rl_next = sl;
                    ql_next = {ql_reg[NUM_W-2:0], 1'b0};
                end
                if (sa >= {1'b0, divisor})
                begin
                    ra_next = sa - {1'b0, divisor};
                    qa_next = {qa_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    ra_next = sa;
                    qa_next = {qa_reg[NUM_W-2:0], 1'b0};
                end
                if (sb >= {1'b0, divisor})
                begin
                    rb_next = sb - {1'b0, divisor};
                    qb_next = {qb_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rb_next = sb;
                    qb_next = {qb_reg[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ql_reg <= ql_next;
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        rl_reg <= rl_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
    end

    assign quo_l = ql_reg;
    assign quo_a = qa_reg;
    assign quo_b = qb_reg;
endmodule
`default_nettype wire

>>> hw/rtl/smms_table.sv
`default_nettype none
// Statistics memory: one wide row per segment, one read and one write port,
// read data registered.
module smms_table
    import smms_pkg::*;
#(
    parameter int ADDR_W = 10,
    parameter int ROW_W  = 145
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]       rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [ROW_W-1:0]  wr_data
);
    logic [ROW_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/segment_masked_mean_stats_core.sv
`default_nettype none
// Per-segment masked mean statistics. Pixel requests may follow back to
// back: the entry is read in the cycle of acceptance, updated and written
// the next cycle, and a pixel to the same segment is forwarded from the
// pending write. A query waits for the bit-serial divider that forms the
// three means and, while an earlier result is still held, for that result
// to be taken; it then clears the entry. After reset a clearing pass walks
// the table, during which no request is accepted. Configuration writes are
// taken at any time.
module segment_masked_mean_stats_core
    import smms_pkg::*;
#(
    parameter int SEGMENTS   = 1024,
    parameter int COUNT_BITS = 22
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    smms_if.sink                       req,
    smms_if.source                     rsp
);
    localparam int ADDR_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int CB     = COUNT_BITS + 1;
    localparam int LSUM_W = LIGHT_W + CB;
    localparam int CSUM_W = CHROMA_W + CB + 1;
    localparam int ROW_W  = LSUM_W + 2 * CSUM_W + 2 * CB;
    localparam int NUM_W  = CSUM_W + 8;
    localparam logic [CB-1:0] COUNT_MAX = CB'(1) << COUNT_BITS;

    typedef struct packed {
        logic [LSUM_W-1:0] lsum;
        logic [CSUM_W-1:0] asum;
        logic [CSUM_W-1:0] bsum;
        logic [CB-1:0]     vcnt;
        logic [CB-1:0]     pcnt;
    } row_t;

    req_t   in_req;
    state_t state_reg, state_next;
    logic [LIGHT_W-1:0] floor_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [ADDR_W:0]    clr_reg, clr_next;

    // stage 1: request accepted, row being read
    logic               p_valid_reg;
    req_t               p_req_reg;
    // pending write, for forwarding
    logic               w_valid_reg;
    logic [ADDR_W-1:0]  w_addr_reg;
    row_t               w_row_reg;

    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [ROW_W-1:0]  rd_data, wr_data;
    row_t              cur, upd;
    row_t              q_row_reg, q_row_next;
    logic [ADDR_W-1:0] p_addr;
    logic              in_range, accept;

    logic              div_start, div_done;
    logic [CB-1:0]     divisor;
    logic [NUM_W-1:0]  num_l, num_a, num_b, quo_l, quo_a, quo_b;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [CSUM_W-1:0] mag_a, mag_b;
    logic [NUM_W-1:0]  sa, sb;
    logic [CB+8:0]     lhs, rhs;

    assign in_req   = req_t'(req.payload);
    assign in_range = 32'(in_req.segment) < SEGMENTS;
    assign p_addr   = ADDR_W'(p_req_reg.segment);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= LIGHT_W'(256);
            ratio_reg <= RATIO_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIGHTNESS_FLOOR: floor_reg <= cfg_data[LIGHT_W-1:0];
                CFG_VALID_RATIO:     ratio_reg <= cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // current row, forwarding the write of the previous cycle
    always_comb
    begin
        if (w_valid_reg && w_addr_reg == p_addr)
            cur = w_row_reg;
        else
            cur = row_t'(rd_data);
        upd = cur;
        if (p_req_reg.lightness > floor_reg && cur.vcnt < COUNT_MAX)
        begin
            upd.lsum = cur.lsum + LSUM_W'(p_req_reg.lightness);
            upd.asum = cur.asum + CSUM_W'($signed(p_req_reg.chroma_a));
            upd.bsum = cur.bsum + CSUM_W'($signed(p_req_reg.chroma_b));
            upd.vcnt = cur.vcnt + 1'b1;
        end
        if (cur.pcnt < COUNT_MAX)
            upd.pcnt = cur.pcnt + 1'b1;
    end

    assign req.ready = (state_reg == ST_IDLE)
                       && !(p_valid_reg && p_req_reg.command == CMD_QUERY);
    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        rd_en = 1'b0;
        rd_addr = ADDR_W'(in_req.segment);
        wr_en = 1'b0;
        wr_addr = p_addr;
        wr_data = ROW_W'(upd);
        q_row_next = q_row_reg;
        div_start = 1'b0;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = clr_reg[ADDR_W-1:0];
                wr_data = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == SEGMENTS - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                rd_en = accept && in_range;
                if (p_valid_reg)
                begin
                    if (p_req_reg.command == CMD_PIXEL)
                        wr_en = 1'b1;
                    else
                    begin
                        q_row_next = cur;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                div_start = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg)
                begin
                    out_next.segment_valid = lhs > rhs;
                    out_next.weight = CNT_W'(q_row_reg.vcnt);
                    out_next.total_count = CNT_W'(q_row_reg.pcnt);
                    if (q_row_reg.vcnt == '0)
                    begin
                        out_next.mean_lightness = '0;
                        out_next.mean_a = '0;
                        out_next.mean_b = '0;
                    end
                    else
                    begin
                        out_next.mean_lightness = quo_l[LIGHT_W-1:0];
                        out_next.mean_a = q_row_reg.asum[CSUM_W-1]
                                          ? MEAN_W'(-quo_a) : quo_a[MEAN_W-1:0];
                        out_next.mean_b = q_row_reg.bsum[CSUM_W-1]
                                          ? MEAN_W'(-quo_b) : quo_b[MEAN_W-1:0];
                    end
                    out_valid_next = 1'b1;
                    wr_en = 1'b1;
                    wr_addr = p_addr;
                    wr_data = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign lhs = {1'b0, q_row_reg.vcnt, 8'd0};
    assign rhs = (CB+9)'(q_row_reg.pcnt) * (CB+9)'(ratio_reg);

    assign mag_a = q_row_reg.asum[CSUM_W-1] ? -q_row_reg.asum : q_row_reg.asum;
    assign mag_b = q_row_reg.bsum[CSUM_W-1] ? -q_row_reg.bsum : q_row_reg.bsum;
    assign sa = {mag_a, 8'd0};
    assign sb = {mag_b, 8'd0};
    assign num_l = NUM_W'(q_row_reg.lsum);
    assign num_a = sa;
    assign num_b = sb;
    assign divisor = q_row_reg.vcnt | CB'(q_row_reg.vcnt == '0);

    smms_div #(.NUM_W(NUM_W), .DEN_W(CB)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_l   (num_l),
        .num_a   (num_a),
        .num_b   (num_b),
        .divisor (divisor),
        .done    (div_done),
        .quo_l   (quo_l),
        .quo_a   (quo_a),
        .quo_b   (quo_b)
    );

    smms_table #(.ADDR_W(ADDR_W), .ROW_W(ROW_W)) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            p_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_IDLE)
                p_valid_reg <= accept && in_range;
            else if (state_reg == ST_OUTPUT && !out_valid_reg)
                p_valid_reg <= 1'b0;
            w_valid_reg <= wr_en && state_reg == ST_IDLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            p_req_reg <= in_req;
        w_addr_reg <= wr_addr;
        w_row_reg <= upd;
        q_row_reg <= q_row_next;
        out_reg <= out_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !req.ready)
        else $error("request accepted during clearing pass");
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside divide state");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_reg))
        else $error("result dropped while stalled");
endmodule
`default_nettype wire
